// ===== design/dswp_pkg.sv =====
// shared types, constants and helpers for the two-axis wave-drive positioner
`default_nettype none

package dswp_pkg;

  localparam int FUNC_W     = 2;
  localparam int CMD_W      = 8;
  localparam int MAX_W      = 16;
  localparam int COIL_W     = 4;
  localparam int POSITION_W = 16;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int POS_BITS_DEF = 16;

  // full-scale command value, the mapping divisor
  localparam int MAP_DIV = (1 << CMD_W) - 1;

  localparam logic [MAX_W-1:0] MAX_STEPS_RST = MAX_W'(2048);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET_X = 2'd1,
    FUNC_SET_Y = 2'd2
  } func_e;

  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 1'd1;

  typedef struct packed {
    logic goal_we;
    logic tick;
  } axis_ctrl_t;

  // one-hot wave drive pattern, phase 0 drives the top coil
  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
    coil_of = 4'b1000 >> phase;
  endfunction

endpackage

`default_nettype wire

// ===== design/dswp_cmd_if.sv =====
// command channel: tick or set-target items
`default_nettype none

interface dswp_cmd_if
  import dswp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CMD_W-1:0]  command_value;

  modport source (output valid, output func, output command_value, input ready);
  modport sink   (input valid, input func, input command_value, output ready);
endinterface

`default_nettype wire

// ===== design/dswp_res_if.sv =====
// result channel: coil patterns and positions after a tick
`default_nettype none

interface dswp_res_if
  import dswp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COIL_W-1:0]     coil_x;
  logic [COIL_W-1:0]     coil_y;
  logic [POSITION_W-1:0] position_x;
  logic [POSITION_W-1:0] position_y;

  modport source (output valid, output coil_x, output coil_y, output position_x,
                  output position_y, input ready);
  modport sink   (input valid, input coil_x, input coil_y, input position_x,
                  input position_y, output ready);
endinterface

`default_nettype wire

// ===== design/dual_stepper_wave_positioner.sv =====
// top level of the two-axis wave-drive stepper positioner
//
//  channel | dir | payload                                   | transfer when
//  cmd     | in  | func, command_value                       | cmd.valid && cmd.ready
//  res     | out | coil_x, coil_y, position_x, position_y    | res.valid && res.ready
//  cfg     | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// one item per cycle; two register stages from command transfer to result
// (input register, then mapping and axis update into the result register)
// a set item gives no result, a tick gives one once it has passed the input register and the result register
// reset clears targets, positions, phases and the pipeline; maxima return to 2048
// a stalled result freezes the whole pipe and drops cmd.ready
`default_nettype none

module dual_stepper_wave_positioner
  import dswp_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  dswp_cmd_if.sink                   cmd,
  dswp_res_if.source                 res
);

  logic                  advance;
  logic [MAX_W-1:0]      x_max_q;
  logic [MAX_W-1:0]      y_max_q;
  logic [MAX_W-1:0]      max_sel;
  logic                  s1_valid_q;
  logic [FUNC_W-1:0]     s1_func_q;
  logic                  s1_tick;
  logic [POS_BITS-1:0]   goal;
  axis_ctrl_t            ctrl_x;
  axis_ctrl_t            ctrl_y;
  logic [POS_BITS-1:0]   pos_x;
  logic [POS_BITS-1:0]   pos_y;
  logic [COIL_W-1:0]     coil_x;
  logic [COIL_W-1:0]     coil_y;
  logic                  res_valid_q;
  logic [COIL_W-1:0]     coil_x_q;
  logic [COIL_W-1:0]     coil_y_q;
  logic [POSITION_W-1:0] position_x_q;
  logic [POSITION_W-1:0] position_y_q;

  assign advance   = !res_valid_q || res.ready;
  assign cmd.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_max_q <= MAX_STEPS_RST;
      y_max_q <= MAX_STEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_MAX: x_max_q <= MAX_W'(cfg_data_i);
        REG_Y_MAX: y_max_q <= MAX_W'(cfg_data_i);
        default:   ;
      endcase
    end
  end

  assign max_sel = (cmd.func == FUNC_SET_Y) ? y_max_q : x_max_q;

  dswp_goal_map #(
    .POS_BITS (POS_BITS)
  ) u_goal_map (
    .clk_i  (clk_i),
    .en_i   (advance),
    .cmd_i  (cmd.command_value),
    .max_i  (max_sel),
    .goal_o (goal)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= cmd.valid;
      res_valid_q <= s1_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_func_q <= cmd.func;
    end
  end

  assign s1_tick = s1_valid_q && (s1_func_q == FUNC_TICK);

  always_comb begin
    ctrl_x.goal_we = advance && s1_valid_q && (s1_func_q == FUNC_SET_X);
    ctrl_x.tick    = advance && s1_tick;
    ctrl_y.goal_we = advance && s1_valid_q && (s1_func_q == FUNC_SET_Y);
    ctrl_y.tick    = advance && s1_tick;
  end

  dswp_axis #(
    .POS_BITS (POS_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_x),
    .goal_i (goal),
    .pos_o  (pos_x),
    .coil_o (coil_x)
  );

  dswp_axis #(
    .POS_BITS (POS_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_y),
    .goal_i (goal),
    .pos_o  (pos_y),
    .coil_o (coil_y)
  );

  always_ff @(posedge clk_i) begin
    if (advance && s1_tick) begin
      coil_x_q     <= coil_x;
      coil_y_q     <= coil_y;
      position_x_q <= POSITION_W'(pos_x);
      position_y_q <= POSITION_W'(pos_y);
    end
  end

  assign res.valid      = res_valid_q;
  assign res.coil_x     = coil_x_q;
  assign res.coil_y     = coil_y_q;
  assign res.position_x = position_x_q;
  assign res.position_y = position_y_q;

  a_tick_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_tick) |=> res_valid_q)
    else $error("tick left the pipe without a result");

  a_set_gives_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !s1_tick) |=> !res_valid_q)
    else $error("result appeared without a tick");

  a_result_held_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res.ready) |=>
      (res_valid_q && $stable(position_x_q) && $stable(position_y_q)))
    else $error("stalled result changed before its transfer");

  a_one_goal_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_x.goal_we, ctrl_y.goal_we, ctrl_x.tick}))
    else $error("more than one axis action in a cycle");

endmodule

`default_nettype wire

// ===== design/dswp_goal_map.sv =====
// command to target: registered command and maximum, multiply, divide by full scale, clamp
`default_nettype none

module dswp_goal_map
  import dswp_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [MAX_W-1:0]    max_i,
  output      logic [POS_BITS-1:0] goal_o
);

  localparam int PROD_W = CMD_W + MAX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QEST_W = SUM_W - CMD_W;
  localparam int REM_W  = PROD_W + 2;
  localparam int QUOT_W = MAX_W;
  localparam int CMP_W  = (POS_BITS > QUOT_W) ? POS_BITS : QUOT_W;

  logic [CMD_W-1:0]    cmd_q;
  logic [MAX_W-1:0]    max_q;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    est;
  logic [QEST_W-1:0]   q_est;
  logic [QEST_W-1:0]   q_fix;
  logic [REM_W-1:0]    rem;
  logic [CMP_W-1:0]    quot;
  logic [CMP_W-1:0]    pos_max;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q <= cmd_i;
      max_q <= max_i;
    end
  end

  always_comb begin
    prod  = PROD_W'(cmd_q) * PROD_W'(max_q);
    // x/255 ~ (x + x/256 + x/65536)/256, never above the true quotient and at most one below
    est   = SUM_W'(prod) + SUM_W'(prod >> CMD_W) + SUM_W'(prod >> (2 * CMD_W));
    q_est = QEST_W'(est >> CMD_W);
    rem   = REM_W'(prod) + REM_W'(q_est) - (REM_W'(q_est) << CMD_W);
    q_fix = q_est + ((rem >= REM_W'(MAP_DIV)) ? QEST_W'(1) : '0);
    quot    = CMP_W'(QUOT_W'(q_fix));
    pos_max = CMP_W'({POS_BITS{1'b1}});
    goal_o  = POS_BITS'((quot > pos_max) ? pos_max : quot);
  end

endmodule

`default_nettype wire

// ===== design/dswp_axis.sv =====
// one axis: target, position and phase state with the single-step move
`default_nettype none

module dswp_axis
  import dswp_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire axis_ctrl_t          ctrl_i,
  input  wire logic [POS_BITS-1:0] goal_i,
  output      logic [POS_BITS-1:0] pos_o,
  output      logic [COIL_W-1:0]   coil_o
);

  logic [POS_BITS-1:0] goal_q;
  logic [POS_BITS-1:0] goal_d;
  logic [POS_BITS-1:0] pos_q;
  logic [POS_BITS-1:0] pos_d;
  logic [PHASE_W-1:0]  phase_q;
  logic [PHASE_W-1:0]  phase_d;

  always_comb begin
    goal_d  = ctrl_i.goal_we ? goal_i : goal_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    if (ctrl_i.tick) begin
      if (pos_q > goal_q) begin
        pos_d   = pos_q - POS_BITS'(1);
        phase_d = phase_q - PHASE_W'(1);
      end else if (pos_q < goal_q) begin
        pos_d   = pos_q + POS_BITS'(1);
        phase_d = phase_q + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q  <= '0;
      pos_q   <= '0;
      phase_q <= '0;
    end else begin
      goal_q  <= goal_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // values after this tick, captured by the result register
  assign pos_o  = pos_d;
  assign coil_o = coil_of(phase_d);

  a_hold_without_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.tick |=> ($stable(pos_q) && $stable(phase_q)))
    else $error("axis state moved without a tick");

  a_idle_at_goal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && pos_q == goal_q) |=> $stable(phase_q))
    else $error("phase advanced while at target");

  a_phase_follows_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && pos_q < goal_q) |=> (phase_q == $past(phase_q) + PHASE_W'(1)))
    else $error("phase did not advance with an upward step");

  a_phase_follows_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && pos_q > goal_q) |=> (phase_q == $past(phase_q) - PHASE_W'(1)))
    else $error("phase did not retreat with a downward step");

endmodule

`default_nettype wire
